// File: design/sorted_table_prefix_range_search_unit_macros.svh
// Assertion macros for the sorted-table prefix range search unit.
// Included by the top level; expects clk and rst_n in scope.
`ifndef SORTED_TABLE_PREFIX_RANGE_SEARCH_UNIT_MACROS_SVH
`define SORTED_TABLE_PREFIX_RANGE_SEARCH_UNIT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define STPRS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define STPRS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/stprs_pkg.sv
// Shared types and constants for the prefix range search unit.
// No dependencies.
package stprs_pkg;

    localparam int KEY_TEXT_W   = 64;
    localparam int SLOT_W       = 6;
    localparam int LEN_W        = 4;
    localparam int REC_W        = 6;
    localparam int ECNT_W       = 7;
    localparam int RESULT_LIMIT = 64;
    localparam int CNT_W        = 6;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 3;
    localparam int REG_IDX_W  = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_ENTRY_COUNT = '0;

    // Result of one prefix compare: eq, or prefix below key (lt).
    typedef struct packed {
        logic eq;
        logic lt;
    } cmp_res_t;

endpackage

// File: design/stprs_ifs.sv
// Request and result channel interfaces (valid/ready).
// Depends on stprs_pkg.
interface stprs_req_if;
    logic                                valid;
    logic                                ready;
    logic                                func;
    logic [stprs_pkg::SLOT_W-1:0]        slot;
    logic [stprs_pkg::KEY_TEXT_W-1:0]    key_text;
    logic [stprs_pkg::LEN_W-1:0]         prefix_len;
    logic [stprs_pkg::REC_W-1:0]         record_num;

    modport source (output valid, func, slot, key_text, prefix_len, record_num,
                    input ready);
    modport sink   (input valid, func, slot, key_text, prefix_len, record_num,
                    output ready);
endinterface

interface stprs_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [stprs_pkg::REC_W-1:0]   match_record;
    logic                          found;
    logic                          last;

    modport source (output valid, match_record, found, last, input ready);
    modport sink   (input valid, match_record, found, last, output ready);
endinterface

// File: design/sorted_table_prefix_range_search_unit.sv
// Top level of the sorted-table prefix range search unit.
// Depends on stprs_pkg, stprs_ifs, stprs_ram, stprs_cmp and the macros header.
//
// Holds up to TABLE_DEPTH keys (top KEY_BYTES characters, first character in
// the top byte) with 6-bit record numbers, loaded in ascending order by load
// requests (func 0). A query request (func 1) binary-searches the first
// entry_count slots for a key whose leading prefix_len characters equal the
// prefix, walks left to the first such key, then returns every matching
// record in table order with last on the final one (at most 64 results).
// No match, or an empty table, gives one result with found 0 and last 1.
// A query passes through a start step, binary search probes (at most
// log2(entry_count)+1 probes), a leftward walk and then the results, each
// held in the output register until the result channel takes it. All of it
// runs through one table RAM with a single registered read port and one
// shared prefix comparator, so each table read is an address state followed
// by a compare state.
// The request side is not ready while a query is in progress. entry_count is
// written over APB at byte address 0 and should only change while the unit
// is idle.
`include "sorted_table_prefix_range_search_unit_macros.svh"

module sorted_table_prefix_range_search_unit #(
    parameter int TABLE_DEPTH = 64,
    parameter int KEY_BYTES   = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    stprs_req_if.sink                             req,
    stprs_rsp_if.source                           rsp,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [stprs_pkg::PADDR_W-1:0]         paddr,
    input  logic [stprs_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [stprs_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                  pready
);

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int NW    = $clog2(TABLE_DEPTH + 1);
    localparam int KW    = 8 * KEY_BYTES;
    localparam int REC_W = stprs_pkg::REC_W;
    localparam int RW    = KW + REC_W;
    localparam int LEN_W = stprs_pkg::LEN_W;
    localparam int CNT_W = stprs_pkg::CNT_W;
    localparam int CW    = (NW > stprs_pkg::ECNT_W) ? NW : stprs_pkg::ECNT_W;
    localparam int SW    = (NW > stprs_pkg::SLOT_W) ? NW : stprs_pkg::SLOT_W;
    localparam int SUMW  = NW + 1;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_S_RD  = 8'b0000_0010,   // search: issue read of midpoint
        ST_S_CMP = 8'b0000_0100,   // search: compare midpoint
        ST_W_RD  = 8'b0000_1000,   // walk left: issue read of idx-1
        ST_W_CMP = 8'b0001_0000,
        ST_E_RD  = 8'b0010_0000,   // emit: look ahead at idx+1
        ST_E_CMP = 8'b0100_0000,
        ST_OUT   = 8'b1000_0000    // result waits in output register
    } state_t;

    state_t                         state_reg, state_next;
    logic [stprs_pkg::ECNT_W-1:0]   entry_count_reg;
    logic [NW-1:0]                  n_reg, n_next;
    logic [NW-1:0]                  lo_reg, lo_next;
    logic [NW-1:0]                  hi_reg, hi_next;     // exclusive upper bound
    logic [AW-1:0]                  mid_reg, mid_next;
    logic [AW-1:0]                  idx_reg, idx_next;
    logic [KW-1:0]                  prefix_reg, prefix_next;
    logic [LEN_W-1:0]               plen_reg, plen_next;
    logic [REC_W-1:0]               pend_rec_reg, pend_rec_next;
    logic [CNT_W-1:0]               cnt_reg, cnt_next;
    logic                           out_valid_reg, out_valid_next;
    logic [REC_W-1:0]               out_rec_reg, out_rec_next;
    logic                           out_found_reg, out_found_next;
    logic                           out_last_reg, out_last_next;

    logic [CW-1:0]                  ecnt_ext;
    logic [NW-1:0]                  n_sat;
    logic                           slot_ok;
    logic [SUMW-1:0]                mid_sum;
    logic [AW-1:0]                  mid_c;
    logic [NW-1:0]                  idx_inc;
    logic [AW-1:0]                  idx_dec;
    logic                           more;

    logic                           ram_we;
    logic [AW-1:0]                  ram_waddr;
    logic [RW-1:0]                  ram_wdata;
    logic                           ram_re;
    logic [AW-1:0]                  ram_raddr;
    logic [RW-1:0]                  ram_rdata;
    logic [REC_W-1:0]               rec_rd;
    stprs_pkg::cmp_res_t            cmp_res;

    logic                           cfg_wr;
    logic [stprs_pkg::REG_IDX_W-1:0] reg_idx;

    // ---------------- APB register ----------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[stprs_pkg::PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = (reg_idx == stprs_pkg::REG_ENTRY_COUNT)
                   ? stprs_pkg::APB_DATA_W'(entry_count_reg) : '0;

    // ---------------- table storage ----------------
    // entry_count saturates at the table depth.
    assign ecnt_ext = CW'(entry_count_reg);
    assign n_sat    = (ecnt_ext > CW'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH) : NW'(ecnt_ext);
    // Loads beyond the table are dropped.
    assign slot_ok  = SW'(req.slot) < SW'(TABLE_DEPTH);

    assign ram_we    = (state_reg == ST_IDLE) && req.valid
                     && (req.func == stprs_pkg::FUNC_LOAD) && slot_ok;
    assign ram_waddr = AW'(req.slot);
    assign ram_wdata = {req.key_text[stprs_pkg::KEY_TEXT_W-1 -: KW], req.record_num};

    stprs_ram #(
        .WIDTH (RW),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rec_rd = ram_rdata[REC_W-1:0];

    // One comparator serves search probes, the left walk and the look-ahead.
    stprs_cmp #(
        .KEY_BYTES (KEY_BYTES)
    ) u_cmp (
        .prefix (prefix_reg),
        .key    (ram_rdata[RW-1 -: KW]),
        .len    (plen_reg),
        .res    (cmp_res)
    );

    // ---------------- address arithmetic ----------------
    // mid = (lo + hi - 1) / 2 with hi exclusive; only used while lo < hi.
    assign mid_sum = SUMW'(lo_reg) + SUMW'(hi_reg) - SUMW'(1);
    assign mid_c   = AW'(mid_sum >> 1);
    assign idx_inc = NW'(idx_reg) + NW'(1);
    assign idx_dec = idx_reg - AW'(1);
    // Another result is possible only below the count and the result limit.
    assign more    = (idx_inc < n_reg)
                   && (cnt_reg != CNT_W'(stprs_pkg::RESULT_LIMIT - 1));

    always_comb
    begin
        ram_re    = 1'b0;
        ram_raddr = mid_c;
        case (state_reg)
            ST_S_RD:
            begin
                ram_re    = (lo_reg < hi_reg);
                ram_raddr = mid_c;
            end
            ST_W_RD:
            begin
                ram_re    = (idx_reg != '0);
                ram_raddr = idx_dec;
            end
            ST_E_RD:
            begin
                ram_re    = more;
                ram_raddr = AW'(idx_inc);
            end
            default:
            begin
                ram_re    = 1'b0;
                ram_raddr = mid_c;
            end
        endcase
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        idx_next       = idx_reg;
        prefix_next    = prefix_reg;
        plen_next      = plen_reg;
        pend_rec_next  = pend_rec_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        out_rec_next   = out_rec_reg;
        out_found_next = out_found_reg;
        out_last_next  = out_last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid && (req.func == stprs_pkg::FUNC_QUERY))
                begin
                    prefix_next = req.key_text[stprs_pkg::KEY_TEXT_W-1 -: KW];
                    plen_next   = (req.prefix_len > LEN_W'(KEY_BYTES))
                                ? LEN_W'(KEY_BYTES) : req.prefix_len;
                    n_next      = n_sat;
                    lo_next     = '0;
                    hi_next     = n_sat;
                    cnt_next    = '0;
                    state_next  = ST_S_RD;
                end
            end
            ST_S_RD:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next   = mid_c;
                    state_next = ST_S_CMP;
                end
                else
                begin
                    // search range empty: single no-match result
                    out_valid_next = 1'b1;
                    out_rec_next   = '0;
                    out_found_next = 1'b0;
                    out_last_next  = 1'b1;
                    state_next     = ST_OUT;
                end
            end
            ST_S_CMP:
            begin
                if (cmp_res.eq)
                begin
                    idx_next      = mid_reg;
                    pend_rec_next = rec_rd;
                    state_next    = ST_W_RD;
                end
                else if (cmp_res.lt)
                begin
                    hi_next    = NW'(mid_reg);
                    state_next = ST_S_RD;
                end
                else
                begin
                    lo_next    = NW'(mid_reg) + NW'(1);
                    state_next = ST_S_RD;
                end
            end
            ST_W_RD:
            begin
                state_next = (idx_reg != '0) ? ST_W_CMP : ST_E_RD;
            end
            ST_W_CMP:
            begin
                if (cmp_res.eq)
                begin
                    idx_next      = idx_dec;
                    pend_rec_next = rec_rd;
                    state_next    = ST_W_RD;
                end
                else
                begin
                    state_next = ST_E_RD;
                end
            end
            ST_E_RD:
            begin
                if (more)
                begin
                    state_next = ST_E_CMP;
                end
                else
                begin
                    out_valid_next = 1'b1;
                    out_rec_next   = pend_rec_reg;
                    out_found_next = 1'b1;
                    out_last_next  = 1'b1;
                    state_next     = ST_OUT;
                end
            end
            ST_E_CMP:
            begin
                // pending record goes out; last unless the next entry matches
                out_valid_next = 1'b1;
                out_rec_next   = pend_rec_reg;
                out_found_next = 1'b1;
                out_last_next  = !cmp_res.eq;
                if (cmp_res.eq)
                begin
                    pend_rec_next = rec_rd;
                    idx_next      = AW'(idx_inc);
                    cnt_next      = cnt_reg + CNT_W'(1);
                end
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (rsp.ready)
                begin
                    out_valid_next = 1'b0;
                    state_next     = out_last_reg ? ST_IDLE : ST_E_RD;
                end
            end
            default:
            begin
                state_next     = ST_IDLE;
                out_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            entry_count_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr && (reg_idx == stprs_pkg::REG_ENTRY_COUNT))
            begin
                entry_count_reg <= pwdata[stprs_pkg::ECNT_W-1:0];
            end
        end
    end

    // Working registers: always set before use, so no reset.
    always_ff @(posedge clk)
    begin
        n_reg         <= n_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mid_reg       <= mid_next;
        idx_reg       <= idx_next;
        prefix_reg    <= prefix_next;
        plen_reg      <= plen_next;
        pend_rec_reg  <= pend_rec_next;
        cnt_reg       <= cnt_next;
        out_rec_reg   <= out_rec_next;
        out_found_reg <= out_found_next;
        out_last_reg  <= out_last_next;
    end

    // ---------------- channel outputs ----------------
    assign req.ready        = (state_reg == ST_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.match_record = out_rec_reg;
    assign rsp.found        = out_found_reg;
    assign rsp.last         = out_last_reg;

    // ---------------- assertions ----------------
    `STPRS_ASSERT_SAME(a_idle_no_result, req.ready, !rsp.valid, "ready while a result is pending")
    `STPRS_ASSERT_SAME(a_nomatch_form, rsp.valid && !rsp.found, rsp.last && (rsp.match_record == '0), "bad no-match result")
    `STPRS_ASSERT_NEXT(a_last_to_idle, rsp.valid && rsp.ready && rsp.last, req.ready, "not idle after last result")

endmodule

// File: design/stprs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module stprs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/stprs_cmp.sv
// Prefix comparator: bytewise unsigned compare over at most len characters.
// Depends on stprs_pkg.
module stprs_cmp #(
    parameter int KEY_BYTES = 8
) (
    input  logic [8*KEY_BYTES-1:0]        prefix,
    input  logic [8*KEY_BYTES-1:0]        key,
    input  logic [stprs_pkg::LEN_W-1:0]   len,
    output stprs_pkg::cmp_res_t           res
);

    localparam int KW = 8 * KEY_BYTES;

    logic       done;
    logic [7:0] a;
    logic [7:0] b;

    // First differing byte decides; a shared NUL ends the compare as equal.
    always_comb
    begin
        done   = 1'b0;
        res.eq = 1'b1;
        res.lt = 1'b0;
        a      = '0;
        b      = '0;
        for (int i = 0; i < KEY_BYTES; i++)
        begin
            a = prefix[KW-1-8*i -: 8];
            b = key[KW-1-8*i -: 8];
            if (!done && (stprs_pkg::LEN_W'(i) < len))
            begin
                if (a != b)
                begin
                    done   = 1'b1;
                    res.eq = 1'b0;
                    res.lt = (a < b);
                end
                else if (a == 8'd0)
                begin
                    done = 1'b1;
                end
            end
        end
    end

endmodule

// File: test/tb.sv
// Testbench for sorted_table_prefix_range_search_unit: table loads, prefix queries, APB setup.
// Depends on stprs_pkg, stprs_ifs and the unit itself; every result is checked
// against a local prediction of the prefix search.
module tb;

    localparam int DEPTH     = 64;
    localparam int NUM_ITEMS = 330;

    localparam int SLOT_W     = stprs_pkg::SLOT_W;
    localparam int LEN_W      = stprs_pkg::LEN_W;
    localparam int REC_W      = stprs_pkg::REC_W;
    localparam int KEY_W      = stprs_pkg::KEY_TEXT_W;
    localparam int ECNT_W     = stprs_pkg::ECNT_W;
    localparam int PADDR_W    = stprs_pkg::PADDR_W;
    localparam int APB_DATA_W = stprs_pkg::APB_DATA_W;

    // Plain ASCII codes used by the directed table.
    localparam logic [7:0] CH_A = 8'h61;
    localparam logic [7:0] CH_Q = 8'h71;

    logic                   clk;
    logic                   rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [PADDR_W-1:0]     paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    stprs_req_if req_ch ();
    stprs_rsp_if rsp_ch ();

    sorted_table_prefix_range_search_unit #(
        .TABLE_DEPTH (DEPTH),
        .KEY_BYTES   (8)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // One result as the unit should deliver it.
    typedef struct {
        logic [REC_W-1:0] rec;
        logic             found;
        logic             last;
    } match_t;

    // Results still owed by the unit, oldest first.
    match_t expected_matches[$];

    // Local image of the table and of entry_count, updated on acceptance.
    logic [KEY_W-1:0]      table_keys [DEPTH];
    logic [REC_W-1:0]      table_recs [DEPTH];
    int unsigned           live_count;

    // Percentage of cycles in which each side holds off; 0 = full speed.
    int idle_pct = 34;

    int errors;
    int items_sent;
    int n_loads;
    int n_queries;
    int n_results;
    int n_misses;
    int burst_len;
    int longest_burst;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Safety net: far beyond the slowest legal run.
    initial
    begin
        #4000000;
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Byte-wise order of prefix against key over len characters:
    // -1 prefix below key, +1 above, 0 equal. A shared zero byte ends the
    // compare as equal, so padding never decides the order.
    function automatic int prefix_order(logic [63:0] pre, logic [63:0] key, int len);
        logic [7:0] a;
        logic [7:0] b;
        for (int i = 0; i < len; i++)
        begin
            a = pre[63 - 8*i -: 8];
            b = key[63 - 8*i -: 8];
            if (a != b)
                return (a < b) ? -1 : 1;
            if (a == 8'd0)
                return 0;
        end
        return 0;
    endfunction

    // Binary search over the live entries, exactly in the unit's probe
    // order, so an unsorted table yields whatever that walk finds. On a hit
    // it walks left to the first equal entry and queues the run of matches
    // (capped at the result limit); otherwise one found=0 result.
    function automatic void predict_prefix_search(logic [63:0] text,
                                                  logic [LEN_W-1:0] plen);
        int     len;
        int     n;
        int     lo;
        int     hi;
        int     mid;
        int     c;
        int     first;
        int     stop;
        match_t m;
        len = (plen > 4'd8) ? 8 : int'(plen);     // long prefix saturates
        n   = (live_count > DEPTH) ? DEPTH : int'(live_count);
        lo  = 0;
        hi  = n - 1;
        while (lo <= hi)
        begin
            mid = (lo + hi) / 2;
            c   = prefix_order(text, table_keys[mid], len);
            if (c == 0)
            begin
                first = mid;
                while (first > 0 && prefix_order(text, table_keys[first-1], len) == 0)
                    first--;
                stop = first;
                while (stop < n && stop - first < stprs_pkg::RESULT_LIMIT &&
                       prefix_order(text, table_keys[stop], len) == 0)
                    stop++;
                for (int k = first; k < stop; k++)
                begin
                    m.rec   = table_recs[k];
                    m.found = 1'b1;
                    m.last  = (k == stop - 1);
                    expected_matches.push_back(m);
                end
                return;
            end
            else if (c < 0)
            begin
                hi = mid - 1;
            end
            else
            begin
                lo = mid + 1;
            end
        end
        m.rec   = '0;
        m.found = 1'b0;
        m.last  = 1'b1;
        expected_matches.push_back(m);
    endfunction

    // ------------------------------------------------------------------
    // Result side: random back-pressure plus the in-order check
    // ------------------------------------------------------------------

    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_ch.ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    always @(posedge clk)
    begin
        match_t want;
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (expected_matches.size() == 0)
            begin
                $error("unexpected result: match_record %0d found %0d last %0d",
                       rsp_ch.match_record, rsp_ch.found, rsp_ch.last);
                errors++;
            end
            else
            begin
                want = expected_matches.pop_front();
                if (rsp_ch.match_record !== want.rec)
                begin
                    $error("match_record: expected %0d, got %0d",
                           want.rec, rsp_ch.match_record);
                    errors++;
                end
                if (rsp_ch.found !== want.found)
                begin
                    $error("found: expected %0d, got %0d", want.found, rsp_ch.found);
                    errors++;
                end
                if (rsp_ch.last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, rsp_ch.last);
                    errors++;
                end
                n_results++;
                if (!want.found)
                    n_misses++;
                burst_len++;
                if (want.last)
                begin
                    if (burst_len > longest_burst)
                        longest_burst = burst_len;
                    burst_len = 0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Offers one request after a random number of idle cycles and waits for
    // the handshake. valid is left high on return so back-to-back requests
    // need no drop; anything that pauses the stream goes through
    // drain_results, which lowers it.
    task automatic send_request(logic func, logic [SLOT_W-1:0] slot,
                                logic [63:0] text, logic [LEN_W-1:0] plen,
                                logic [REC_W-1:0] rec);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.func       <= func;
        req_ch.slot       <= slot;
        req_ch.key_text   <= text;
        req_ch.prefix_len <= plen;
        req_ch.record_num <= rec;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        if (func == stprs_pkg::FUNC_LOAD)
        begin
            table_keys[slot] = text;
            table_recs[slot] = rec;
            n_loads++;
        end
        else
        begin
            predict_prefix_search(text, plen);
            n_queries++;
        end
        items_sent++;
    endtask

    // Stops offering requests and waits until every owed result has come,
    // then lets the unit settle.
    task automatic drain_results(int settle);
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (expected_matches.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // APB write of entry_count followed by a read-back. Only called idle.
    task automatic write_entry_count(logic [ECNT_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {stprs_pkg::REG_ENTRY_COUNT, 2'b00};
        pwdata  <= APB_DATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);                 // pready is tied high: written here
        live_count = value;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[ECNT_W-1:0] !== value)
        begin
            $error("entry_count: expected %0d, got %0d", value, prdata[ECNT_W-1:0]);
            errors++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Random key: mostly short strings over a three-letter alphabet so that
    // prefixes collide often; now and then a fully random 64-bit pattern.
    function automatic logic [63:0] make_key();
        logic [63:0] k;
        int          chars;
        if ($urandom_range(7) == 0)
            return {$urandom, $urandom};
        k     = '0;
        chars = $urandom_range(0, 8);
        for (int i = 0; i < chars; i++)
            k[63 - 8*i -: 8] = CH_A + 8'($urandom_range(2));
        return k;
    endfunction

    // Loads slots 0..n-1 with random keys, sorted unless asked otherwise.
    // A nonzero lead byte forces a common first character on every key.
    task automatic load_table(int n, bit sorted_keys, logic [7:0] lead);
        logic [63:0] keys [DEPTH];
        logic [63:0] t;
        int          j;
        for (int i = 0; i < n; i++)
        begin
            t = make_key();
            keys[i] = (lead != 8'd0) ? {lead, t[63:8]} : t;
        end
        if (sorted_keys)
        begin
            for (int i = 1; i < n; i++)
            begin
                t = keys[i];
                j = i - 1;
                while (j >= 0 && keys[j] > t)
                begin
                    keys[j+1] = keys[j];
                    j--;
                end
                keys[j+1] = t;
            end
        end
        for (int i = 0; i < n; i++)
            send_request(stprs_pkg::FUNC_LOAD, SLOT_W'(i), keys[i], LEN_W'($urandom),
                         REC_W'($urandom));
    endtask

    // Random query: mostly a live key's prefix (hits, with junk beyond the
    // compared length), some over-long lengths, some pure noise.
    task automatic send_query();
        logic [63:0] text;
        int          pick;
        int          len;
        int          n_live;
        n_live = (live_count > DEPTH) ? DEPTH : int'(live_count);
        pick   = $urandom_range(99);
        if (n_live > 0 && pick < 70)
        begin
            text = table_keys[$urandom_range(n_live - 1)];
            len  = $urandom_range(0, 8);
            if ($urandom_range(1) == 1)
                text = text | ({$urandom, $urandom} >> (8 * len));
        end
        else if (pick < 85)
        begin
            text = make_key();
            len  = $urandom_range(9, 15);
        end
        else
        begin
            text = {$urandom, $urandom};
            len  = $urandom_range(15);
        end
        send_request(stprs_pkg::FUNC_QUERY, SLOT_W'($urandom), text, LEN_W'(len),
                     REC_W'($urandom));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Empty table: any query, even a zero-length one, gives a single miss.
    task automatic test_empty_table();
        write_entry_count(7'd0);
        send_request(stprs_pkg::FUNC_QUERY, 6'd0, {CH_A, 56'd0}, 4'd1, 6'd0);
        send_request(stprs_pkg::FUNC_QUERY, 6'd63, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 6'd63);
        drain_results(8);
    endtask

    // Hand-built eight-entry table: empty key, "a", "ab", "abc", "abd", "b",
    // "ba" and an all-ones key, then hits, misses on both sides, zero and
    // saturated lengths, and a query on the empty-string key.
    task automatic test_small_table();
        send_request(stprs_pkg::FUNC_LOAD, 6'd0, 64'd0,                       4'd0,  6'd0);
        send_request(stprs_pkg::FUNC_LOAD, 6'd1, {CH_A, 56'd0},               4'd15, 6'd63);
        send_request(stprs_pkg::FUNC_LOAD, 6'd2, {CH_A, 8'h62, 48'd0},        4'd0,  6'd5);
        send_request(stprs_pkg::FUNC_LOAD, 6'd3, {CH_A, 8'h62, 8'h63, 40'd0}, 4'd0,  6'd21);
        send_request(stprs_pkg::FUNC_LOAD, 6'd4, {CH_A, 8'h62, 8'h64, 40'd0}, 4'd0,  6'd42);
        send_request(stprs_pkg::FUNC_LOAD, 6'd5, {8'h62, 56'd0},              4'd0,  6'd9);
        send_request(stprs_pkg::FUNC_LOAD, 6'd6, {8'h62, CH_A, 48'd0},        4'd0,  6'd17);
        send_request(stprs_pkg::FUNC_LOAD, 6'd7, 64'hFFFF_FFFF_FFFF_FFFF,     4'd0,  6'd33);
        drain_results(8);
        write_entry_count(7'd8);
        // "ab" over two chars: ab, abc, abd
        send_request(stprs_pkg::FUNC_QUERY, 6'd0, {CH_A, 8'h62, 48'd0}, 4'd2, 6'd0);
        // "a" over one char: four hits
        send_request(stprs_pkg::FUNC_QUERY, 6'd0, {CH_A, 56'd0}, 4'd1, 6'd0);
        // zero length matches every live entry
        send_request(stprs_pkg::FUNC_QUERY, 6'd0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 6'd0);
        // length 15 saturates to 8: only the exact "ab"
        send_request(stprs_pkg::FUNC_QUERY, 6'd0, {CH_A, 8'h62, 48'd0}, 4'd15, 6'd0);
        // all-zero prefix hits only the empty key
        send_request(stprs_pkg::FUNC_QUERY, 6'd0, 64'd0, 4'd8, 6'd0);
        send_request(stprs_pkg::FUNC_QUERY, 6'd0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 6'd0);
        // misses: between entries, and between "abd" and "b"
        send_request(stprs_pkg::FUNC_QUERY, 6'd0, {8'h63, 56'd0}, 4'd1, 6'd0);
        send_request(stprs_pkg::FUNC_QUERY, 6'd0, {CH_A, 8'h62, 8'h65, 40'd0}, 4'd3, 6'd0);
        drain_results(8);
    endtask

    // Full 64-entry table sharing a first character, at full speed on both
    // sides: 64-result bursts, then entry_count above the depth.
    task automatic test_full_table();
        idle_pct = 0;
        load_table(DEPTH, 1'b1, CH_Q);
        drain_results(8);
        write_entry_count(7'd64);
        send_request(stprs_pkg::FUNC_QUERY, 6'd0, {CH_Q, 56'd0}, 4'd1, 6'd0);
        send_request(stprs_pkg::FUNC_QUERY, 6'd0, 64'd0, 4'd0, 6'd0);
        repeat (4) send_query();
        drain_results(8);
        write_entry_count(7'd127);
        send_request(stprs_pkg::FUNC_QUERY, 6'd0, {CH_Q, 56'd0}, 4'd1, 6'd0);
        repeat (3) send_query();
        drain_results(8);
        idle_pct = 34;
    endtask

    // Random phases: reload a table of random size (mostly small, a few
    // large, some unsorted), set entry_count to the size or below, then a
    // burst of queries. The drain before each register write is where the
    // request stream pauses until every owed result is in.
    task automatic test_random_tables();
        int n;
        bit sorted_keys;
        while (items_sent < NUM_ITEMS)
        begin
            n           = ($urandom_range(5) == 0) ? $urandom_range(17, DEPTH)
                                                   : $urandom_range(1, 16);
            sorted_keys = ($urandom_range(7) != 0);
            load_table(n, sorted_keys, 8'd0);
            drain_results(8);
            write_entry_count(($urandom_range(5) == 0) ? ECNT_W'($urandom_range(0, n))
                                                       : ECNT_W'(n));
            repeat ($urandom_range(4, 14)) send_query();
        end
        drain_results(20);
    endtask

    initial
    begin
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        req_ch.valid      = 1'b0;
        req_ch.func       = stprs_pkg::FUNC_LOAD;
        req_ch.slot       = '0;
        req_ch.key_text   = '0;
        req_ch.prefix_len = '0;
        req_ch.record_num = '0;
        live_count        = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_table();
        test_small_table();
        test_full_table();
        test_random_tables();

        $display("Ran %0d table loads and %0d prefix queries; %0d results checked, %0d misses.",
                 n_loads, n_queries, n_results, n_misses);
        $display("Longest burst %0d results; entry_count went from 0 through 64 to 127.",
                 longest_burst);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
